// ===== rtl/tpdk_pkg.sv =====
package tpdk_pkg;

	localparam int DIST_W = 16;
	localparam int WEIGHT_W = 16;
	localparam int IN_FRAC_BITS_DEF = 12;
	localparam int OUT_FRAC_BITS_DEF = 16;
	localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;

	typedef enum logic [1:0] {
		BR_ZERO,
		BR_OUTER,
		BR_INNER
	} br_t;

	typedef struct packed {
		logic vld;
		br_t br;
	} ctl_t;

endpackage

// ===== rtl/three_point_delta_kernel_core.sv =====
// Three-point immersed-boundary delta kernel, fully pipelined.
// Input channel: distance (signed, IN_FRAC_BITS fraction bits) with
// distance_valid / distance_stall. Output channel: weight (unsigned,
// OUT_FRAC_BITS fraction bits) with weight_valid / weight_stall.
// One item may enter each unstalled cycle; one weight leaves per item, in order.
// The pipeline length is set mostly by the square-root pipeline, which
// resolves one root bit per stage; the root carries PREC fraction bits,
// PREC = max(OUT_FRAC_BITS + 6, IN_FRAC_BITS).
// Throughput: one item per cycle while the receiver takes results.
// When the receiver stalls, the finished weight moves into a one-entry
// skid register; distance_stall then rises (it is that register's full
// flag) and the whole pipe holds until the receiver takes the item.
// Reset clears all valid bits, the skid full flag among them; no state survives
// between items, so nothing else needs clearing.
module three_point_delta_kernel_core #(
	parameter int IN_FRAC_BITS = tpdk_pkg::IN_FRAC_BITS_DEF,
	parameter int OUT_FRAC_BITS = tpdk_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic distance_valid,
	output logic distance_stall,
	input  logic signed [tpdk_pkg::DIST_W-1:0] distance,
	output logic weight_valid,
	input  logic weight_stall,
	output logic [tpdk_pkg::WEIGHT_W-1:0] weight
);

	localparam int IN = IN_FRAC_BITS;
	localparam int PREC = (OUT_FRAC_BITS + 6 > IN) ? OUT_FRAC_BITS + 6 : IN;
	localparam int UP = PREC - IN;
	localparam int DN = PREC - OUT_FRAC_BITS;
	localparam int RW = PREC + 1;
	localparam int XW = 2 * RW;
	localparam int AW = IN + 1;
	localparam int CW = (IN + 3 > 18) ? IN + 3 : 18;
	localparam int NW = PREC + 3;
	localparam int UW = OUT_FRAC_BITS + 4;
	localparam int QW = (UW > tpdk_pkg::WEIGHT_W + 1) ? UW : tpdk_pkg::WEIGHT_W + 1;
	localparam int AGW = 2 * IN + 1;
	localparam logic [UW-1:0] RECIP3 = UW'(((64'd1) << UW) / 3);

	logic en;
	logic skid_vld_q;
	logic [tpdk_pkg::WEIGHT_W-1:0] skid_w_q;

	assign en = !skid_vld_q;
	assign distance_stall = skid_vld_q;

	// stage 1: magnitude, branch, distance to the nearer lattice point
	logic [16:0] a_abs;
	logic [CW-1:0] a_ext;
	logic [CW-1:0] one_c;
	logic [CW-1:0] x_full;
	tpdk_pkg::ctl_t ctl_c;

	tpdk_pkg::ctl_t ctl_s1;
	logic [IN-1:0] x_s1;
	logic [AW-1:0] a_s1;

	always_comb begin
		a_abs = distance[tpdk_pkg::DIST_W-1] ? (~{1'b1, distance} + 17'd1)
			: {1'b0, distance};
		a_ext = CW'(a_abs);
		one_c = CW'(1) << IN;
		ctl_c.vld = distance_valid;
		if ((a_ext << 1) > (CW'(3) << IN)) begin
			ctl_c.br = tpdk_pkg::BR_ZERO;
		end else if ((a_ext << 1) > one_c) begin
			ctl_c.br = tpdk_pkg::BR_OUTER;
		end else begin
			ctl_c.br = tpdk_pkg::BR_INNER;
		end
		if (ctl_c.br == tpdk_pkg::BR_OUTER) begin
			x_full = (a_ext > one_c) ? a_ext - one_c : one_c - a_ext;
		end else begin
			x_full = a_ext;
		end
	end

	// stage 2: square
	tpdk_pkg::ctl_t ctl_s2;
	logic [2*IN-1:0] sq_c;
	logic [2*IN-1:0] sq_s2;
	logic [AW-1:0] a_s2;

	assign sq_c = x_s1 * x_s1;

	// stage 3: radicand, scaled to 2*PREC fraction bits
	tpdk_pkg::ctl_t ctl_s3;
	logic [AGW-1:0] arg_c;
	logic [XW-1:0] rad_s3;
	logic [AW-1:0] a_s3;

	assign arg_c = (AGW'(1) << (2 * IN)) - (AGW'(sq_s2) + (AGW'(sq_s2) << 1));

	// square root pipeline
	logic [RW-1:0] root_sq;
	logic [AW-1:0] a_sq;
	tpdk_pkg::ctl_t ctl_sq;

	tpdk_sqrt #(
		.RW(RW),
		.AW(AW)
	) u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.radicand(rad_s3),
		.tag_a(a_s3),
		.tag_ctl(ctl_s3),
		.root(root_sq),
		.root_a(a_sq),
		.root_ctl(ctl_sq)
	);

	// stage 4: numerator in units of 2^-PREC
	tpdk_pkg::ctl_t ctl_s4;
	logic [NW-1:0] am_c;
	logic [NW-1:0] num_c;
	logic [NW-1:0] num_s4;

	always_comb begin
		am_c = NW'(a_sq) << UP;
		case (ctl_sq.br)
			tpdk_pkg::BR_OUTER: num_c = (NW'(5) << PREC) - (am_c + (am_c << 1)) - NW'(root_sq);
			default: num_c = (NW'(1) << PREC) + NW'(root_sq);
		endcase
	end

	// stage 5: round and drop to OUT_FRAC_BITS; the /6 case takes a halving first
	tpdk_pkg::ctl_t ctl_s5;
	logic [NW:0] sum_c;
	logic [UW-1:0] t_c;
	logic [UW-1:0] u_c;
	logic [UW-1:0] u_s5;

	always_comb begin
		if (ctl_s4.br == tpdk_pkg::BR_OUTER) begin
			sum_c = (NW+1)'(num_s4) + ((NW+1)'(3) << DN);
		end else begin
			sum_c = (NW+1)'(num_s4) + ((NW+1)'(3) << (DN - 1));
		end
		t_c = UW'(sum_c >> DN);
		u_c = (ctl_s4.br == tpdk_pkg::BR_OUTER) ? (t_c >> 1) : t_c;
	end

	// stage 6: divide by 3 via reciprocal multiply (estimate low by at most one)
	tpdk_pkg::ctl_t ctl_s6;
	logic [2*UW-1:0] prod_s6;
	logic [UW-1:0] u_s6;

	// stage 7: correct quotient, saturate, zero branch
	tpdk_pkg::ctl_t ctl_s7;
	logic [UW-1:0] q0_c;
	logic [UW+1:0] r_c;
	logic [QW-1:0] q_c;
	logic [tpdk_pkg::WEIGHT_W-1:0] w_c;
	logic [tpdk_pkg::WEIGHT_W-1:0] w_s7;

	always_comb begin
		q0_c = prod_s6[2*UW-1:UW];
		r_c = (UW+2)'(u_s6) - ((UW+2)'(q0_c) + ((UW+2)'(q0_c) << 1));
		q_c = QW'(q0_c) + ((r_c >= (UW+2)'(3)) ? QW'(1) : QW'(0));
		case (ctl_s6.br)
			tpdk_pkg::BR_OUTER, tpdk_pkg::BR_INNER: begin
				if (q_c > QW'(tpdk_pkg::WEIGHT_MAX)) begin
					w_c = tpdk_pkg::WEIGHT_MAX;
				end else begin
					w_c = q_c[tpdk_pkg::WEIGHT_W-1:0];
				end
			end
			default: w_c = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_c;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_sq;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= x_full[IN-1:0];
			a_s1 <= a_ext[AW-1:0];
			sq_s2 <= sq_c;
			a_s2 <= a_s1;
			rad_s3 <= XW'(arg_c) << (2 * UP);
			a_s3 <= a_s2;
			num_s4 <= num_c;
			u_s5 <= u_c;
			prod_s6 <= u_s5 * RECIP3;
			u_s6 <= u_s5;
			w_s7 <= w_c;
		end
	end

	// skid register: catches the last stage when the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (!skid_vld_q) begin
			skid_vld_q <= ctl_s7.vld & weight_stall;
		end else if (!weight_stall) begin
			skid_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_vld_q) begin
			skid_w_q <= w_s7;
		end
	end

	assign weight_valid = skid_vld_q | ctl_s7.vld;
	assign weight = skid_vld_q ? skid_w_q : w_s7;

endmodule

// ===== rtl/tpdk_sqrt.sv =====
module tpdk_sqrt #(
	parameter int RW = 23,
	parameter int AW = 13
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic [2*RW-1:0] radicand,
	input  logic [AW-1:0] tag_a,
	input  tpdk_pkg::ctl_t tag_ctl,
	output logic [RW-1:0] root,
	output logic [AW-1:0] root_a,
	output tpdk_pkg::ctl_t root_ctl
);

	localparam int XW = 2 * RW;

	logic [XW-1:0] rem_w [0:RW-1];
	logic [RW-1:0] root_w [0:RW];
	logic [AW-1:0] a_w [0:RW];
	tpdk_pkg::ctl_t ctl_w [0:RW];

	assign rem_w[0] = radicand;
	assign root_w[0] = '0;
	assign a_w[0] = tag_a;
	assign ctl_w[0] = tag_ctl;

	// one root bit per stage, MSB first; rem holds radicand minus root squared
	for (genvar i = 0; i < RW; i++) begin : g_bit
		localparam int K = RW - 1 - i;
		logic [XW-1:0] d;
		logic [XW-1:0] rem_nx;
		logic [RW-1:0] root_nx;
		logic [RW-1:0] root_s;
		logic [AW-1:0] a_s;
		tpdk_pkg::ctl_t ctl_s;

		always_comb begin
			d = (XW'(root_w[i]) << (K + 1)) | (XW'(1) << (2 * K));
			rem_nx = rem_w[i];
			root_nx = root_w[i];
			if (rem_w[i] >= d) begin
				rem_nx = rem_w[i] - d;
				root_nx = root_w[i] | (RW'(1) << K);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s <= '0;
			end else if (en) begin
				ctl_s <= ctl_w[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				root_s <= root_nx;
				a_s <= a_w[i];
			end
		end

		if (i < RW - 1) begin : g_rem
			logic [XW-1:0] rem_s;
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s <= rem_nx;
				end
			end
			assign rem_w[i+1] = rem_s;
		end

		assign root_w[i+1] = root_s;
		assign a_w[i+1] = a_s;
		assign ctl_w[i+1] = ctl_s;
	end

	assign root = root_w[RW];
	assign root_a = a_w[RW];
	assign root_ctl = ctl_w[RW];

endmodule

// ===== rtl/tpdk_checker.sv =====
module tpdk_checker (
	input logic clk,
	input logic arst_n,
	input logic distance_stall,
	input logic weight_valid,
	input logic weight_stall,
	input logic [tpdk_pkg::WEIGHT_W-1:0] weight
);

	// a stalled item stays on the output unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		weight_valid && weight_stall |=> weight_valid && $stable(weight))
		else $error("weight changed or dropped while stalled");

	// input back-pressure only comes from a result waiting on a stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(distance_stall) |-> $past(weight_valid && weight_stall))
		else $error("distance_stall rose without a stalled result");

	// while the input is held off there is a result waiting
	a_stall_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		distance_stall |-> weight_valid)
		else $error("distance_stall with no result waiting");

	// back-pressure clears in the cycle after the receiver takes the item
	a_stall_release: assert property (@(posedge clk) disable iff (!arst_n)
		distance_stall && !weight_stall |=> !distance_stall)
		else $error("distance_stall held after the receiver took the item");

endmodule

bind three_point_delta_kernel_core tpdk_checker u_tpdk_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	localparam int IN_FB = tpdk_pkg::IN_FRAC_BITS_DEF;
	localparam int OUT_FB = tpdk_pkg::OUT_FRAC_BITS_DEF;
	localparam int PREC = (OUT_FB + 6 > IN_FB) ? (OUT_FB + 6) : IN_FB;
	localparam int UP = PREC - IN_FB;
	localparam int DOWN = PREC - OUT_FB;

	localparam int N_RAND = 1950;
	localparam int IDLE_END = 1650;
	localparam int HOLD_AT = 400;
	localparam int HOLD_LEN = 200;
	localparam int DRAIN = 64;
	localparam int LIMIT = 400000;
	localparam int MAX_SHOWN = 10;

	typedef struct {
		logic [tpdk_pkg::DIST_W-1:0] distance;
		bit fixed;
		logic [tpdk_pkg::WEIGHT_W-1:0] wt;
	} dist_vec_t;

	typedef struct {
		logic [tpdk_pkg::DIST_W-1:0] distance;
		logic [tpdk_pkg::WEIGHT_W-1:0] wt;
	} pending_wt_t;

	localparam int N_DIR = 22;
	// fixed weights: zero outside 1.5, 2/3 at the center, 1/2 at 0.5, 1/6 at 1.0
	dist_vec_t dir_vecs [N_DIR] = '{
		'{16'h0000, 1'b1, 16'd43691},
		'{16'h7fff, 1'b1, 16'd0},
		'{16'h8000, 1'b1, 16'd0},
		'{16'h8001, 1'b1, 16'd0},
		'{16'd6145, 1'b1, 16'd0},
		'{-16'sd6145, 1'b1, 16'd0},
		'{16'd6144, 1'b1, 16'd0},
		'{-16'sd6144, 1'b1, 16'd0},
		'{16'd6143, 1'b0, 16'd0},
		'{16'd4096, 1'b1, 16'd10923},
		'{-16'sd4096, 1'b1, 16'd10923},
		'{16'd4095, 1'b0, 16'd0},
		'{16'd4097, 1'b0, 16'd0},
		'{16'd2048, 1'b1, 16'd32768},
		'{-16'sd2048, 1'b1, 16'd32768},
		'{16'd2049, 1'b0, 16'd0},
		'{-16'sd2049, 1'b0, 16'd0},
		'{16'd2047, 1'b0, 16'd0},
		'{16'd1, 1'b0, 16'd0},
		'{16'hffff, 1'b0, 16'd0},
		'{16'h5555, 1'b1, 16'd0},
		'{16'haaaa, 1'b1, 16'd0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic distance_valid = 1'b0;
	logic distance_stall;
	logic signed [tpdk_pkg::DIST_W-1:0] distance = '0;
	logic weight_valid;
	logic weight_stall = 1'b0;
	logic [tpdk_pkg::WEIGHT_W-1:0] weight;

	bit cur_fixed = 1'b0;
	logic [tpdk_pkg::WEIGHT_W-1:0] cur_fw = '0;

	pending_wt_t weight_q [$];
	int accepted_cnt = 0;
	int mismatch_cnt = 0;
	int cycle_cnt = 0;
	int sent_cnt = 0;
	int stall_left = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	three_point_delta_kernel_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.distance_valid(distance_valid),
		.distance_stall(distance_stall),
		.distance(distance),
		.weight_valid(weight_valid),
		.weight_stall(weight_stall),
		.weight(weight)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint unsigned floor_sqrt(longint unsigned x);
		longint unsigned r;
		longint unsigned cand;
		r = 0;
		for (int i = 31; i >= 0; i--) begin
			cand = r | (64'd1 << i);
			if (cand * cand <= x)
				r = cand;
		end
		return r;
	endfunction

	function automatic logic [tpdk_pkg::WEIGHT_W-1:0] delta_weight(
			logic [tpdk_pkg::DIST_W-1:0] raw);
		longint unsigned a, one, one2, b, arg, root, num, den, w;
		a = raw[tpdk_pkg::DIST_W-1] ? (64'd65536 - raw) : raw;
		one = 64'd1 << IN_FB;
		one2 = 64'd1 << (2 * IN_FB);
		if (2 * a > 3 * one) begin
			w = 0;
		end else if (2 * a > one) begin
			b = (a > one) ? (a - one) : (one - a);
			arg = one2 - 3 * b * b;
			root = floor_sqrt(arg << (2 * UP));
			num = 5 * (64'd1 << PREC) - 3 * (a << UP) - root;
			den = 64'd6 << DOWN;
			w = (num + (den >> 1)) / den;
		end else begin
			arg = one2 - 3 * a * a;
			root = floor_sqrt(arg << (2 * UP));
			num = (64'd1 << PREC) + root;
			den = 64'd3 << DOWN;
			w = (num + (den >> 1)) / den;
		end
		if (w > tpdk_pkg::WEIGHT_MAX)
			w = tpdk_pkg::WEIGHT_MAX;
		return w[tpdk_pkg::WEIGHT_W-1:0];
	endfunction

	task automatic flag_error(string what, logic [tpdk_pkg::DIST_W-1:0] d,
			logic [tpdk_pkg::WEIGHT_W-1:0] want, logic [tpdk_pkg::WEIGHT_W-1:0] got);
		mismatch_cnt++;
		if (mismatch_cnt <= MAX_SHOWN)
			$display("%s: distance %0d expected %0d got %0d", what, $signed(d), want, got);
	endtask

	// result check first, then record the item taken at this edge
	always @(posedge clk) begin
		pending_wt_t head;
		if (arst_n) begin
			if (weight_valid && !weight_stall) begin
				if (weight_q.size() == 0) begin
					flag_error("unexpected weight", '0, '0, weight);
				end else begin
					head = weight_q.pop_front();
					if (weight !== head.wt)
						flag_error("weight mismatch", head.distance, head.wt, weight);
				end
			end
			if (distance_valid && !distance_stall) begin
				head.distance = distance;
				head.wt = cur_fixed ? cur_fw : delta_weight(distance);
				weight_q.push_back(head);
				accepted_cnt++;
			end
		end
	end

	// long hold-off, counted once enough items went in, to back up the pipe
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_LEN;
		end
	end

	// receiver: follows the hold-off, otherwise random stall bursts
	always @(negedge clk) begin
		if (hold_left > 0) begin
			weight_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			weight_stall <= 1'b1;
		end else if (accepted_cnt < IDLE_END && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(1, 9) - 1;
			weight_stall <= 1'b1;
		end else begin
			weight_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > LIMIT) begin
			$display("three_point_delta_kernel_core: mismatch");
			$finish;
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic offer_item(logic [tpdk_pkg::DIST_W-1:0] d, bit fx,
			logic [tpdk_pkg::WEIGHT_W-1:0] fw);
		int gap;
		if (sent_cnt < IDLE_END && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 9);
			distance_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		distance_valid <= 1'b1;
		distance <= d;
		cur_fixed <= fx;
		cur_fw <= fw;
		@(posedge clk);
		while (distance_stall)
			@(posedge clk);
		sent_cnt++;
		@(negedge clk);
	endtask

	initial begin
		int sel;
		int v;
		int base;
		logic [31:0] r32;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_DIR; i++)
			offer_item(dir_vecs[i].distance, dir_vecs[i].fixed, dir_vecs[i].wt);

		for (int i = 0; i < N_RAND; i++) begin
			sel = $urandom_range(0, 9);
			if (sel < 6) begin
				v = int'($urandom_range(0, 12400)) - 6200;
			end else if (sel < 8) begin
				// near the branch edges and the lattice point at 1.0
				case ($urandom_range(0, 2))
					0: base = 2048;
					1: base = 4096;
					default: base = 6144;
				endcase
				v = base + int'($urandom_range(0, 8)) - 4;
				if ($urandom_range(0, 1))
					v = -v;
			end else begin
				r32 = $urandom();
				v = int'(r32[15:0]);
			end
			offer_item(v[tpdk_pkg::DIST_W-1:0], 1'b0, '0);
		end
		distance_valid <= 1'b0;

		while (weight_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (mismatch_cnt == 0 && weight_q.size() == 0)
			$display("three_point_delta_kernel_core: match");
		else
			$display("three_point_delta_kernel_core: mismatch");
		$finish;
	end

endmodule
